@@ rtl/pcrel_pkg.sv @@
// Shared types, constants and helper functions of the PC-relative relocator.
package pcrel_pkg;

  // Fixed encodings used in the emitted sequences.
  localparam logic [31:0] BrX16     = 32'hD61F_0200;
  localparam logic [31:0] OpB       = 32'h1400_0000;
  localparam logic [31:0] OpLdrLitX = 32'h5800_0000;
  localparam logic [31:0] LdrLitM8  = 32'h00FF_FFC0;  // imm19 of -8 bytes, shifted into place
  localparam logic [4:0]  RegX16    = 5'd16;

  // Depth of the queue between the decoder and the sequencer.
  localparam int unsigned QueueDepthDefault = 2;

  // Width of the word counter of one emitted sequence (up to seven words).
  localparam int unsigned StepW = 3;

  // What the sequencer has to produce for one instruction.
  typedef enum logic [2:0] {
    KIND_COPY,  // word copied unchanged
    KIND_BAD,   // refused form, one flagged zero word
    KIND_ADR,   // absolute load into the destination
    KIND_B,     // absolute load of x16 plus br x16
    KIND_LIT,   // absolute load of x16 plus load from [x16]
    KIND_COND   // retargeted conditional, skip, jump block
  } pcrel_kind_e;

  // One decoded instruction as it waits in the queue.
  typedef struct packed {
    pcrel_kind_e kind;
    logic [4:0]  reg_idx;  // register of the literal load
    logic [31:0] word;     // copied word, retargeted conditional or final load
    logic [63:0] target;   // absolute address or value to materialize
  } pcrel_desc_t;

  // Index of the final word of a sequence.
  function automatic logic [StepW-1:0] last_step(pcrel_kind_e kind);
    logic [StepW-1:0] s;
    s = '0;
    unique case (kind)
      KIND_COPY, KIND_BAD: s = 3'd0;
      KIND_ADR:            s = 3'd3;
      KIND_B, KIND_LIT:    s = 3'd4;
      KIND_COND:           s = 3'd6;
      default:             s = 3'd0;
    endcase
    return s;
  endfunction

  // Unsigned-offset load from [x16] that replaces a literal load.
  function automatic logic [31:0] lit_load(logic simd, logic [1:0] opc, logic [4:0] rt);
    logic [31:0] base;
    base = 32'h0;
    if (simd) begin
      case (opc)
        2'd0:    base = 32'hBD40_0000;
        2'd1:    base = 32'hFD40_0000;
        default: base = 32'h3DC0_0000;
      endcase
    end else begin
      case (opc)
        2'd0:    base = 32'hB940_0000;
        2'd1:    base = 32'hF940_0000;
        default: base = 32'hB980_0000;
      endcase
    end
    return base | {22'd0, RegX16, rt};
  endfunction

endpackage

@@ rtl/pcrel_front.sv @@
// Decoder: classifies one instruction and computes its absolute target.
module pcrel_front import pcrel_pkg::*; (
  input  logic [31:0] instr_i,
  input  logic [63:0] orig_pc_i,
  output pcrel_desc_t desc_o
);

  logic [31:0] w;
  logic [63:0] offset;
  logic [63:0] base;
  logic        page;

  assign w = instr_i;

  // Classify the word and pick the sign-extended displacement.
  always_comb begin
    desc_o.kind    = KIND_COPY;
    desc_o.reg_idx = RegX16;
    desc_o.word    = w;
    offset         = '0;
    page           = 1'b0;
    if ((w & 32'h9F00_0000) == 32'h1000_0000 || (w & 32'h9F00_0000) == 32'h9000_0000) begin
      desc_o.kind    = KIND_ADR;
      desc_o.reg_idx = w[4:0];
      if (w[31]) begin
        page   = 1'b1;
        offset = {{31{w[23]}}, w[23:5], w[30:29], 12'd0};
      end else begin
        offset = {{43{w[23]}}, w[23:5], w[30:29]};
      end
    end else if (w[31:26] == 6'b000101) begin
      desc_o.kind = KIND_B;
      offset      = {{36{w[25]}}, w[25:0], 2'd0};
    end else if (w[31:26] == 6'b100101 || (w & 32'hFFFF_FC1F) == 32'hD63F_0000) begin
      desc_o.kind = KIND_BAD;
    end else if (w[31:24] == 8'h54 && !w[4]) begin
      desc_o.kind = KIND_COND;
      desc_o.word = (w & 32'hFF00_000F) | 32'h0000_0040;
      offset      = {{43{w[23]}}, w[23:5], 2'd0};
    end else if (w[31:24] == 8'h54) begin
      desc_o.kind = KIND_BAD;
    end else if ((w & 32'h7E00_0000) == 32'h3400_0000) begin
      desc_o.kind = KIND_COND;
      desc_o.word = (w & 32'hFF00_001F) | 32'h0000_0040;
      offset      = {{43{w[23]}}, w[23:5], 2'd0};
    end else if ((w & 32'h7E00_0000) == 32'h3600_0000) begin
      desc_o.kind = KIND_COND;
      desc_o.word = (w & 32'hFFF8_001F) | 32'h0000_0040;
      offset      = {{48{w[18]}}, w[18:5], 2'd0};
    end else if ((w & 32'h3B00_0000) == 32'h1800_0000) begin
      if (w[31:30] == 2'b11) begin
        desc_o.kind = KIND_BAD;
      end else begin
        desc_o.kind = KIND_LIT;
        desc_o.word = lit_load(w[26], w[31:30], w[4:0]);
        offset      = {{43{w[23]}}, w[23:5], 2'd0};
      end
    end

    // One 64-bit address sum, wrapping.
    base          = page ? {orig_pc_i[63:12], 12'd0} : orig_pc_i;
    desc_o.target = base + offset;
  end

endmodule

@@ rtl/pcrel_queue.sv @@
// Short queue of decoded instructions between decoder and sequencer.
module pcrel_queue import pcrel_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  pcrel_desc_t push_data_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        head_valid_o,
  output pcrel_desc_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  pcrel_desc_t     entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o       = (count_q == FullCnt);
  assign head_valid_o = (count_q != '0);
  assign head_o       = entry_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/pcrel_back.sv @@
// Sequencer: walks one decoded instruction and emits its words one per cycle unless the output stalls.
module pcrel_back import pcrel_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  pcrel_desc_t head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] word_o,
  output logic        last_o,
  output logic        unrelocatable_o
);

  logic [StepW-1:0] step_q, step_d;
  logic [StepW-1:0] blk;
  logic             fire;
  logic             at_last;
  logic             valid_q, valid_d;
  logic [31:0]      word_q, word_d;
  logic             last_q;
  logic             unrel_q, unrel_d;

  // A word moves into the output register whenever the queue holds one and that register is empty or being read out.
  assign fire    = head_valid_i && (!valid_q || !out_stall_i);
  assign at_last = (step_q == last_step(head_i.kind));
  assign pop_o   = fire && at_last;

  // Position inside the absolute-load block.
  assign blk = (head_i.kind == KIND_COND) ? step_q - 3'd2 : step_q;

  // Word selection for the current position.
  always_comb begin
    word_d  = 32'h0;
    unrel_d = 1'b0;
    if (head_i.kind == KIND_COPY) begin
      word_d = head_i.word;
    end else if (head_i.kind == KIND_BAD) begin
      unrel_d = 1'b1;
    end else if (head_i.kind == KIND_COND && step_q == 3'd0) begin
      word_d = head_i.word;
    end else if (head_i.kind == KIND_COND && step_q == 3'd1) begin
      word_d = OpB | 32'd6;
    end else begin
      case (blk)
        3'd0:    word_d = OpB | 32'd3;
        3'd1:    word_d = head_i.target[31:0];
        3'd2:    word_d = head_i.target[63:32];
        3'd3:    word_d = OpLdrLitX | LdrLitM8 | {27'd0, head_i.reg_idx};
        default: word_d = (head_i.kind == KIND_LIT) ? head_i.word : BrX16;
      endcase
    end
  end

  // Step counter and output valid.
  always_comb begin
    step_d  = step_q;
    valid_d = valid_q && out_stall_i;
    if (fire) begin
      valid_d = 1'b1;
      step_d  = at_last ? '0 : step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  // Output payload, loaded on each transfer into the register.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      word_q  <= word_d;
      last_q  <= at_last;
      unrel_q <= unrel_d;
    end
  end

  assign out_valid_o     = valid_q;
  assign word_o          = word_q;
  assign last_o          = last_q;
  assign unrelocatable_o = unrel_q;

endmodule

@@ rtl/aarch64_pc_relative_relocator.sv @@
// Top level: decoder, queue and word sequencer of the PC-relative relocator.
// The first word of an instruction passes through a queue entry and then the output register.
// Throughput: one word per cycle while out_stall_i is low; an instruction emits
// 1 word (copy or refused), 4 (ADR/ADRP), 5 (B, literal load) or 7 (conditional).
// The single-word result port of the sequencer sets that figure.
// Reset (rst_ni low, asynchronous) empties the queue and clears the output valid.
module aarch64_pc_relative_relocator import pcrel_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] instr_i,
  input  logic [63:0] orig_pc_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] word_o,
  output logic        last_o,
  output logic        unrelocatable_o
);

  pcrel_desc_t desc;
  pcrel_desc_t head;
  logic        full;
  logic        push;
  logic        pop;
  logic        head_valid;

  assign in_stall_o = full;
  assign push       = in_valid_i && !full;

  pcrel_front u_front (
    .instr_i   (instr_i),
    .orig_pc_i (orig_pc_i),
    .desc_o    (desc)
  );

  pcrel_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (desc),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  pcrel_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .word_o          (word_o),
    .last_o          (last_o),
    .unrelocatable_o (unrelocatable_o)
  );

endmodule

@@ rtl/pcrel_checker.sv @@
// Port-level assertions of the relocator and their bind to the top level.
module pcrel_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] word_o,
  input logic        last_o,
  input logic        unrelocatable_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(word_o) && $stable(last_o)
      && $stable(unrelocatable_o))
    else $error("stalled result changed");

  // A refused form is a single zero word closing its sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unrelocatable_o |-> last_o && word_o == 32'h0)
    else $error("refused result is not a lone zero word");

  // Once a sequence has started, its words follow without a gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("gap inside a word sequence");

endmodule

bind aarch64_pc_relative_relocator pcrel_checker u_pcrel_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .word_o          (word_o),
  .last_o          (last_o),
  .unrelocatable_o (unrelocatable_o)
);
